/* src/tclb_pkg.sv */
// Shared types, widths, command codes and defaults for the text console line buffer.
package tclb_pkg;

   localparam int NUM_ROWS_DEF     = 256;
   localparam int ROW_LEN_DEF      = 128;
   localparam int NOTIFY_DEPTH_DEF = 8;

   localparam int CMD_W   = 3;
   localparam int BYTE_W  = 8;
   localparam int TIME_W  = 32;
   localparam int ROW_W   = 8;
   localparam int COL_W   = 7;
   localparam int SLOT_W  = 3;
   localparam int SPAN_W  = 9;

   typedef logic [CMD_W-1:0]  cmd_port_type;
   typedef logic [BYTE_W-1:0] byte_port_type;
   typedef logic [TIME_W-1:0] time_port_type;
   typedef logic [ROW_W-1:0]  row_port_type;
   typedef logic [COL_W-1:0]  col_port_type;
   typedef logic [SLOT_W-1:0] slot_port_type;
   typedef logic [SPAN_W-1:0] span_port_type;

   localparam cmd_port_type CMD_PRINT     = 3'd0;
   localparam cmd_port_type CMD_CLEAR     = 3'd1;
   localparam cmd_port_type CMD_READ_TEXT = 3'd2;
   localparam cmd_port_type CMD_READ_SPAN = 3'd3;
   localparam cmd_port_type CMD_READ_TIME = 3'd4;

   localparam byte_port_type CH_CR = 8'd13;
   localparam byte_port_type CH_LF = 8'd10;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic fetch;
      logic exec;
      logic spill;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic spill_needed;
   } stat_type;

endpackage

/* src/tclb_ctrl.sv */
// Controller state machine that sequences each item through fetch and update, and a spill when one is needed.
module tclb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output logic               rsp_valid,
   output tclb_pkg::ctl_type  ctl,
   input  tclb_pkg::stat_type stat
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EXEC,
      ST_SPILL
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (stat.spill_needed) begin
               state_in = ST_SPILL;
            end else begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         ST_SPILL: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign ctl.load  = start && (state_ff == ST_IDLE);
   assign ctl.fetch = (state_ff == ST_FETCH);
   assign ctl.exec  = (state_ff == ST_EXEC);
   assign ctl.spill = (state_ff == ST_SPILL);

endmodule

/* src/tclb_datapath.sv */
// Datapath with the text store, row tables, notify ring and write position registers.
module tclb_datapath #(
   parameter int NUM_ROWS     = tclb_pkg::NUM_ROWS_DEF,
   parameter int ROW_LEN      = tclb_pkg::ROW_LEN_DEF,
   parameter int NOTIFY_DEPTH = tclb_pkg::NOTIFY_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tclb_pkg::ctl_type       ctl,
   output tclb_pkg::stat_type      stat,
   input  tclb_pkg::cmd_port_type  req_cmd,
   input  tclb_pkg::byte_port_type req_ch,
   input  tclb_pkg::time_port_type req_now,
   input  tclb_pkg::row_port_type  req_row,
   input  tclb_pkg::col_port_type  req_col,
   input  tclb_pkg::slot_port_type req_slot,
   output tclb_pkg::byte_port_type rsp_data,
   output tclb_pkg::span_port_type rsp_span,
   output tclb_pkg::time_port_type rsp_stamp,
   output tclb_pkg::row_port_type  rsp_cur_row,
   output tclb_pkg::col_port_type  rsp_column,
   output tclb_pkg::span_port_type rsp_rows_used,
   output logic                    rsp_ignored
);

   localparam int RW  = $clog2(NUM_ROWS);
   localparam int CW  = $clog2(ROW_LEN);
   localparam int FW  = $clog2(ROW_LEN + 1);
   localparam int SW  = $clog2(NUM_ROWS + 1);
   localparam int AW  = $clog2(NUM_ROWS * ROW_LEN);
   localparam int NIW = (NOTIFY_DEPTH > 1) ? $clog2(NOTIFY_DEPTH) : 1;

   // Latched item.
   tclb_pkg::cmd_port_type  cmd_ff;
   tclb_pkg::byte_port_type ch_ff;
   tclb_pkg::time_port_type now_ff;
   tclb_pkg::row_port_type  row_ff;
   tclb_pkg::col_port_type  col_ff;
   tclb_pkg::slot_port_type slot_ff;

   // Console state.
   logic [RW-1:0]       write_row_ff, write_row_in;
   logic [CW-1:0]       write_col_ff, write_col_in;
   logic [RW-1:0]       start_row_ff, start_row_in;
   logic [SW-1:0]       start_span_ff, start_span_in;
   logic [SW-1:0]       used_ff, used_in;
   logic                ready_ff, ready_in;
   logic [NIW-1:0]      nidx_ff, nidx_in;
   logic [31:0]         notify_ff [NOTIFY_DEPTH];
   logic [31:0]         notify_in [NOTIFY_DEPTH];
   logic [NUM_ROWS-1:0] valid_ff, valid_in;

   // Memories and their registered read data.
   logic [7:0]    text_mem [NUM_ROWS * ROW_LEN];
   logic [SW-1:0] span_mem [NUM_ROWS];
   logic [FW-1:0] fill_mem [NUM_ROWS];
   logic [7:0]    text_rd_ff;
   logic [SW-1:0] span_rd_ff;
   logic [FW-1:0] fill_rd_ff;
   logic          span_ok_ff;
   logic          fill_ok_ff;

   // Result registers.
   tclb_pkg::byte_port_type data_ff, data_in;
   tclb_pkg::span_port_type span_ff, span_in;
   tclb_pkg::time_port_type stamp_ff, stamp_in;
   logic                    ignored_ff, ignored_in;

   // Memory write controls.
   logic          text_we;
   logic [AW-1:0] text_wr_addr;
   logic          span_we;
   logic [RW-1:0] span_wr_addr;
   logic [SW-1:0] span_wr_data;
   logic          fill_we;
   logic [RW-1:0] fill_wr_addr;
   logic [FW-1:0] fill_wr_data;

   // Derived values.
   logic [RW-1:0]  row_idx;
   logic [CW-1:0]  col_idx;
   logic [NIW-1:0] slot_idx;
   logic           row_in_range;
   logic           col_in_range;
   logic           slot_in_range;
   logic [RW-1:0]  next_row;
   logic           col_last;
   logic           wraps_self;
   logic           is_print;
   logic           is_cr;
   logic           is_lf;
   logic [AW-1:0]  text_rd_addr;
   logic [RW-1:0]  fill_rd_addr;
   logic [RW-1:0]  span_rd_addr;
   logic [SW-1:0]  old_span;
   logic [SW:0]    used_p1;
   logic [SW:0]    old_ext;
   logic [SW:0]    taken_diff;
   logic [SW-1:0]  taken_used;
   logic [FW-1:0]  fill_cur;
   logic [FW-1:0]  col_p1;
   logic [FW-1:0]  fill_new;
   logic [SW-1:0]  start_span_inc;

   assign row_idx       = RW'(row_ff);
   assign col_idx       = CW'(col_ff);
   assign slot_idx      = NIW'(slot_ff);
   assign row_in_range  = (32'(row_ff) < 32'(NUM_ROWS));
   assign col_in_range  = (32'(col_ff) < 32'(ROW_LEN));
   assign slot_in_range = (32'(slot_ff) < 32'(NOTIFY_DEPTH));

   assign next_row   = (write_row_ff == RW'(NUM_ROWS - 1)) ? '0 : write_row_ff + RW'(1);
   assign col_last   = (write_col_ff == CW'(ROW_LEN - 1));
   assign wraps_self = (next_row == start_row_ff);
   assign is_print   = (cmd_ff == tclb_pkg::CMD_PRINT) && ready_ff;
   assign is_cr      = (ch_ff == tclb_pkg::CH_CR);
   assign is_lf      = (ch_ff == tclb_pkg::CH_LF);

   assign stat.spill_needed = is_print && !is_cr && !is_lf && col_last;

   assign text_rd_addr = AW'(row_idx * ROW_LEN) + AW'(col_idx);
   assign text_wr_addr = AW'(write_row_ff * ROW_LEN) + AW'(write_col_ff);
   assign fill_rd_addr = is_print ? write_row_ff : row_idx;
   assign span_rd_addr = is_print ? next_row : row_idx;

   // Used-row adjustment when a row is taken over: add one, less its old span.
   assign old_span   = span_ok_ff ? span_rd_ff : '0;
   assign used_p1    = (SW + 1)'(used_ff) + (SW + 1)'(1);
   assign old_ext    = (SW + 1)'(old_span);
   assign taken_diff = used_p1 - old_ext;
   always_comb begin
      if (old_ext > used_p1) begin
         taken_used = '0;
      end else if (taken_diff > (SW + 1)'(NUM_ROWS)) begin
         taken_used = SW'(NUM_ROWS);
      end else begin
         taken_used = SW'(taken_diff);
      end
   end

   assign fill_cur       = fill_ok_ff ? fill_rd_ff : '0;
   assign col_p1         = FW'(write_col_ff) + FW'(1);
   assign fill_new       = (col_p1 > fill_cur) ? col_p1 : fill_cur;
   assign start_span_inc = (start_span_ff == SW'(NUM_ROWS)) ? start_span_ff
                                                            : start_span_ff + SW'(1);

   always_comb begin
      write_row_in  = write_row_ff;
      write_col_in  = write_col_ff;
      start_row_in  = start_row_ff;
      start_span_in = start_span_ff;
      used_in       = used_ff;
      ready_in      = ready_ff;
      nidx_in       = nidx_ff;
      notify_in     = notify_ff;
      valid_in      = valid_ff;
      data_in       = data_ff;
      span_in       = span_ff;
      stamp_in      = stamp_ff;
      ignored_in    = ignored_ff;
      text_we       = 1'b0;
      span_we       = 1'b0;
      span_wr_addr  = next_row;
      span_wr_data  = '0;
      fill_we       = 1'b0;
      fill_wr_addr  = next_row;
      fill_wr_data  = '0;

      if (ctl.exec) begin
         data_in    = '0;
         span_in    = '0;
         stamp_in   = '0;
         ignored_in = 1'b0;
         case (cmd_ff)
            tclb_pkg::CMD_PRINT: begin
               if (!ready_ff) begin
                  ignored_in = 1'b1;
               end else if (is_cr) begin
                  write_row_in = start_row_ff;
                  write_col_in = '0;
               end else if (is_lf) begin
                  notify_in[nidx_ff] = now_ff;
                  nidx_in = (nidx_ff == NIW'(NOTIFY_DEPTH - 1)) ? '0 : nidx_ff + NIW'(1);
                  write_row_in       = next_row;
                  write_col_in       = '0;
                  used_in            = taken_used;
                  start_row_in       = next_row;
                  start_span_in      = SW'(1);
                  valid_in[next_row] = 1'b1;
                  span_we            = 1'b1;
                  span_wr_data       = SW'(1);
                  fill_we            = 1'b1;
               end else begin
                  text_we      = 1'b1;
                  fill_we      = 1'b1;
                  fill_wr_addr = write_row_ff;
                  fill_wr_data = fill_new;
                  write_col_in = col_last ? '0 : write_col_ff + CW'(1);
                  if (col_last && !wraps_self) begin
                     start_span_in = start_span_inc;
                     span_we       = 1'b1;
                     span_wr_addr  = start_row_ff;
                     span_wr_data  = start_span_inc;
                  end
               end
            end
            tclb_pkg::CMD_CLEAR: begin
               write_row_in  = '0;
               write_col_in  = '0;
               start_row_in  = '0;
               start_span_in = SW'(1);
               used_in       = SW'(1);
               ready_in      = 1'b1;
               nidx_in       = '0;
               for (int i = 0; i < NOTIFY_DEPTH; i++) begin
                  notify_in[i] = '0;
               end
               valid_in      = '0;
               valid_in[0]   = 1'b1;
               span_we       = 1'b1;
               span_wr_addr  = '0;
               span_wr_data  = SW'(1);
               fill_we       = 1'b1;
               fill_wr_addr  = '0;
            end
            tclb_pkg::CMD_READ_TEXT: begin
               if (row_in_range && col_in_range && fill_ok_ff
                   && (FW'(col_idx) < fill_rd_ff)) begin
                  data_in = text_rd_ff;
               end
            end
            tclb_pkg::CMD_READ_SPAN: begin
               if (row_in_range && span_ok_ff) begin
                  span_in = tclb_pkg::span_port_type'(span_rd_ff);
               end
            end
            tclb_pkg::CMD_READ_TIME: begin
               if (slot_in_range) begin
                  stamp_in = notify_ff[slot_idx];
               end
            end
            default: begin
            end
         endcase
      end

      // Second half of a row spill: open the next row, or reuse the start row.
      if (ctl.spill) begin
         write_row_in = next_row;
         fill_we      = 1'b1;
         if (!wraps_self) begin
            used_in            = taken_used;
            valid_in[next_row] = 1'b1;
            span_we            = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_row_ff  <= '0;
         write_col_ff  <= '0;
         start_row_ff  <= '0;
         start_span_ff <= '0;
         used_ff       <= '0;
         ready_ff      <= 1'b0;
         nidx_ff       <= '0;
         valid_ff      <= '0;
         for (int i = 0; i < NOTIFY_DEPTH; i++) begin
            notify_ff[i] <= '0;
         end
      end else begin
         write_row_ff  <= write_row_in;
         write_col_ff  <= write_col_in;
         start_row_ff  <= start_row_in;
         start_span_ff <= start_span_in;
         used_ff       <= used_in;
         ready_ff      <= ready_in;
         nidx_ff       <= nidx_in;
         valid_ff      <= valid_in;
         notify_ff     <= notify_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff  <= req_cmd;
         ch_ff   <= req_ch;
         now_ff  <= req_now;
         row_ff  <= req_row;
         col_ff  <= req_col;
         slot_ff <= req_slot;
      end
      data_ff    <= data_in;
      span_ff    <= span_in;
      stamp_ff   <= stamp_in;
      ignored_ff <= ignored_in;
   end

   always_ff @(posedge clock) begin
      if (text_we) begin
         text_mem[text_wr_addr] <= ch_ff;
      end
      if (ctl.fetch) begin
         text_rd_ff <= text_mem[text_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (span_we) begin
         span_mem[span_wr_addr] <= span_wr_data;
      end
      if (ctl.fetch) begin
         span_rd_ff <= span_mem[span_rd_addr];
         span_ok_ff <= valid_ff[span_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[fill_wr_addr] <= fill_wr_data;
      end
      if (ctl.fetch) begin
         fill_rd_ff <= fill_mem[fill_rd_addr];
         fill_ok_ff <= valid_ff[fill_rd_addr];
      end
   end

   assign rsp_data      = data_ff;
   assign rsp_span      = span_ff;
   assign rsp_stamp     = stamp_ff;
   assign rsp_ignored   = ignored_ff;
   assign rsp_cur_row   = tclb_pkg::row_port_type'(write_row_ff);
   assign rsp_column    = tclb_pkg::col_port_type'(write_col_ff);
   assign rsp_rows_used = tclb_pkg::span_port_type'(used_ff);

endmodule

/* src/text_console_line_buffer.sv */
// Top level of the text console line buffer: controller and datapath.
//
// An item (print, clear or one of three reads) is taken at a rising edge where
// start is high and busy is low. Busy then stays high while the item runs, and
// longer when a printed character fills the last column of a row and the line
// spills into the next row. In the cycle in which busy falls, rsp_valid is
// high for one cycle with the item's result; every result carries the write
// row, column and used-row count after the item. The receiver cannot hold
// results off. An item first reads the row tables and text store, whose read
// data is registered, then updates them, and a spill needs a second write to
// the row table. A new item may be started in the cycle in which the previous
// result is shown.
// Reset clears the write position, the used-row count, the row valid bits and
// the notify times; the row spans and the text store are not cleared. Prints
// are ignored until the first clear, which needs no pass over the rows, since
// rows are marked empty at once and the text of an empty row reads as zero.
module text_console_line_buffer #(
   parameter int NUM_ROWS     = tclb_pkg::NUM_ROWS_DEF,
   parameter int ROW_LEN      = tclb_pkg::ROW_LEN_DEF,
   parameter int NOTIFY_DEPTH = tclb_pkg::NOTIFY_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  tclb_pkg::cmd_port_type  req_cmd,
   input  tclb_pkg::byte_port_type req_ch,
   input  tclb_pkg::time_port_type req_now,
   input  tclb_pkg::row_port_type  req_row,
   input  tclb_pkg::col_port_type  req_col,
   input  tclb_pkg::slot_port_type req_slot,
   output logic                    rsp_valid,
   output tclb_pkg::byte_port_type rsp_data,
   output tclb_pkg::span_port_type rsp_span,
   output tclb_pkg::time_port_type rsp_stamp,
   output tclb_pkg::row_port_type  rsp_cur_row,
   output tclb_pkg::col_port_type  rsp_column,
   output tclb_pkg::span_port_type rsp_rows_used,
   output logic                    rsp_ignored
);

   tclb_pkg::ctl_type  ctl;
   tclb_pkg::stat_type stat;

   tclb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctl       (ctl),
      .stat      (stat)
   );

   tclb_datapath #(
      .NUM_ROWS     (NUM_ROWS),
      .ROW_LEN      (ROW_LEN),
      .NOTIFY_DEPTH (NOTIFY_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .stat          (stat),
      .req_cmd       (req_cmd),
      .req_ch        (req_ch),
      .req_now       (req_now),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_slot      (req_slot),
      .rsp_data      (rsp_data),
      .rsp_span      (rsp_span),
      .rsp_stamp     (rsp_stamp),
      .rsp_cur_row   (rsp_cur_row),
      .rsp_column    (rsp_column),
      .rsp_rows_used (rsp_rows_used),
      .rsp_ignored   (rsp_ignored)
   );

endmodule
